[rtl/core/ftr_pkg.sv]
// Shared types, constants and the 5x7 glyph table for the text rasterizer.
`timescale 1ns / 1ps

package ftr_pkg;

  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned MASK_W     = GLYPH_ROWS * GLYPH_COLS;

  localparam logic [10:0] CURSOR_MAX = 11'd2047;
  localparam logic [11:0] ADVANCE    = 12'd6;

  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_DASH = 8'h2D;

  typedef logic [4:0] glyph_rows_t [GLYPH_ROWS];

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic emit;
  } ftr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mask_empty;
    logic cur_bit;
    logic out_free;
  } ftr_status_t;

  localparam glyph_rows_t LETTER_ROM [26] = '{
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
  };

  localparam glyph_rows_t DIGIT_ROM [10] = '{
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
  };

  localparam glyph_rows_t DASH_GLYPH  = '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
  localparam glyph_rows_t BLANK_GLYPH = '{5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0};

  // Unknown codes map to an empty glyph, so they draw nothing.
  function automatic glyph_rows_t glyph_lookup(input logic [7:0] code);
    glyph_rows_t rows;
    if (code >= CH_A && code <= CH_Z) begin
      rows = LETTER_ROM[5'(code - CH_A)];
    end else if (code >= CH_0 && code <= CH_9) begin
      rows = DIGIT_ROM[4'(code - CH_0)];
    end else if (code == CH_DASH) begin
      rows = DASH_GLYPH;
    end else begin
      rows = BLANK_GLYPH;
    end
    return rows;
  endfunction

endpackage

[rtl/core/ftr_if.sv]
// Valid/ready channel interfaces for character input and pixel output.
`timescale 1ns / 1ps

interface ftr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       new_string;
  logic [9:0] start_x;
  logic [9:0] start_y;
  logic [7:0] ink_color;

  modport source (output valid, char_code, new_string, start_x, start_y, ink_color,
                  input ready);
  modport sink (input valid, char_code, new_string, start_x, start_y, ink_color,
                output ready);
endinterface

interface ftr_pixel_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_color;
  logic       last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                output ready);
endinterface

[rtl/core/ftr_ctrl.sv]
// Sequencer: accepts a character, prepares its pixel mask, then walks the mask.
`timescale 1ns / 1ps

module ftr_ctrl import ftr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_valid_i,
  output logic        char_ready_o,
  input  ftr_status_t status_i,
  output ftr_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    char_ready_o = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        char_ready_o = 1'b1;
        if (char_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.mask_empty) begin
          state_d = ST_IDLE;
        end else begin
          // blank positions step freely, set ones wait for room at the output
          cmd_o.step = !status_i.cur_bit || status_i.out_free;
          cmd_o.emit = status_i.cur_bit && status_i.out_free;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/ftr_datapath.sv]
// Pen state, glyph lookup, clip mask and the pixel output register.
`timescale 1ns / 1ps

module ftr_datapath import ftr_pkg::*; #(
  parameter int unsigned FB_WIDTH  = 320,
  parameter int unsigned FB_HEIGHT = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ftr_cmd_t    cmd_i,
  output ftr_status_t status_o,
  input  logic [7:0]  char_code_i,
  input  logic        new_string_i,
  input  logic [9:0]  start_x_i,
  input  logic [9:0]  start_y_i,
  input  logic [7:0]  ink_color_i,
  output logic        pixel_valid_o,
  input  logic        pixel_ready_i,
  output logic [8:0]  pixel_x_o,
  output logic [7:0]  pixel_y_o,
  output logic [7:0]  pixel_color_o,
  output logic        last_pixel_o
);

  logic [10:0]       cursor_q, cursor_d;
  logic [9:0]        pen_y_q, pen_y_d;
  logic [7:0]        pen_color_q, pen_color_d;
  logic [10:0]       base_x_q;
  glyph_rows_t       rows_q;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [2:0]        col_q, row_q;

  logic [10:0]       base_x_d;
  logic [11:0]       adv_sum;
  logic [GLYPH_COLS-1:0] x_vis;
  logic [GLYPH_ROWS-1:0] y_vis;
  logic [11:0]       px;
  logic [10:0]       py;

  logic              out_valid_q;

  assign base_x_d = new_string_i ? {1'b0, start_x_i} : cursor_q;
  assign adv_sum  = {1'b0, base_x_d} + ADVANCE;

  always_comb begin
    cursor_d    = cursor_q;
    pen_y_d     = pen_y_q;
    pen_color_d = pen_color_q;
    if (cmd_i.load) begin
      cursor_d = adv_sum[11] ? CURSOR_MAX : adv_sum[10:0];
      if (new_string_i) begin
        pen_y_d     = start_y_i;
        pen_color_d = ink_color_i;
      end
    end
  end

  // Visible set bits of the glyph, index row * 5 + column, column 0 is the MSB.
  always_comb begin
    for (int c = 0; c < GLYPH_COLS; c++) begin
      x_vis[c] = ({1'b0, base_x_q} + 12'(c)) < 12'(FB_WIDTH);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      y_vis[r] = ({1'b0, pen_y_q} + 11'(r)) < 11'(FB_HEIGHT);
    end
    mask_d = mask_q;
    if (cmd_i.prep) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
          mask_d[r*GLYPH_COLS + c] = rows_q[r][GLYPH_COLS-1-c] & x_vis[c] & y_vis[r];
        end
      end
    end else if (cmd_i.step) begin
      mask_d = mask_q >> 1;
    end
  end

  assign px = {1'b0, base_x_q} + {9'd0, col_q};
  assign py = {1'b0, pen_y_q} + {8'd0, row_q};

  assign status_o.mask_empty = (mask_q == '0);
  assign status_o.cur_bit    = mask_q[0];
  assign status_o.out_free   = !out_valid_q || pixel_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      pen_y_q     <= '0;
      pen_color_q <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      pen_y_q     <= pen_y_d;
      pen_color_q <= pen_color_d;
      mask_q      <= mask_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (pixel_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_x_q <= base_x_d;
      rows_q   <= glyph_lookup(char_code_i);
    end
    if (cmd_i.prep) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.step) begin
      if (col_q == 3'(GLYPH_COLS - 1)) begin
        col_q <= '0;
        row_q <= row_q + 3'd1;
      end else begin
        col_q <= col_q + 3'd1;
      end
    end
    if (cmd_i.emit) begin
      pixel_x_o     <= px[8:0];
      pixel_y_o     <= py[7:0];
      pixel_color_o <= pen_color_q;
      // last when no visible bit remains above the current one
      last_pixel_o  <= (mask_q[MASK_W-1:1] == '0);
    end
  end

  assign pixel_valid_o = out_valid_q;

endmodule

[rtl/core/font_text_rasterizer_top.sv]
// Top level of the 5x7 text rasterizer.
`timescale 1ns / 1ps

// One character beat in, one pixel beat out per visible glyph pixel. Each
// character is accepted in the idle state, then its 35-bit clipped pixel
// mask is built, then the walk visits each glyph position up to the last
// set bit of that mask (at most 35) and returns to idle; a character with
// no visible pixel goes straight back. The walk moves one position a cycle,
// but a set position waits while the pixel output has no room.
// The pixel output is registered, so a pixel waiting to be taken does not
// hold the walk over blank positions.
module font_text_rasterizer_top import ftr_pkg::*; #(
  parameter int unsigned FB_WIDTH  = 320,
  parameter int unsigned FB_HEIGHT = 200
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ftr_char_if.sink     char_i,
  ftr_pixel_if.source  pixel_o
);

  ftr_cmd_t    cmd;
  ftr_status_t status;

  ftr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_i.valid),
    .char_ready_o (char_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ftr_datapath #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .char_code_i   (char_i.char_code),
    .new_string_i  (char_i.new_string),
    .start_x_i     (char_i.start_x),
    .start_y_i     (char_i.start_y),
    .ink_color_i   (char_i.ink_color),
    .pixel_valid_o (pixel_o.valid),
    .pixel_ready_i (pixel_o.ready),
    .pixel_x_o     (pixel_o.pixel_x),
    .pixel_y_o     (pixel_o.pixel_y),
    .pixel_color_o (pixel_o.pixel_color),
    .last_pixel_o  (pixel_o.last_pixel)
  );

endmodule

[tb/font_text_rasterizer_top_tb.sv]
// Self-checking testbench for the 5x7 text rasterizer: directed table, then random strings.
`timescale 1ns / 1ps

module font_text_rasterizer_top_tb;
  import ftr_pkg::*;

  localparam int unsigned FB_W = 320;
  localparam int unsigned FB_H = 200;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0] char_code;
    logic       new_string;
    logic [9:0] start_x;
    logic [9:0] start_y;
    logic [7:0] ink_color;
  } char_beat_t;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_color;
    logic       last_pixel;
  } pixel_beat_t;

  // typed: expectation written in the row (no pixels, or a dash drawn in full)
  typedef struct packed {
    logic [7:0] char_code;
    logic       new_string;
    logic [9:0] start_x;
    logic [9:0] start_y;
    logic [7:0] ink_color;
    logic       typed;
    logic [2:0] n_typed;
  } font_case_t;

  typedef logic [4:0] font_rows_t [7];

  localparam font_rows_t ALPHA_FONT [26] = '{
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
  };

  localparam font_rows_t NUMERAL_FONT [10] = '{
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
  };

  localparam font_rows_t HYPHEN_FONT = '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
  localparam font_rows_t EMPTY_FONT  = '{5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0};

  localparam int N_CASES = 22;
  localparam font_case_t FONT_CASES [N_CASES] = '{
    '{8'h41, 1'b0, 10'd0,    10'd0,    8'h00, 1'b0, 3'd0},  // 'A' on reset pen
    '{8'h5A, 1'b0, 10'd0,    10'd0,    8'h00, 1'b0, 3'd0},  // 'Z' at cursor 6
    '{8'h2D, 1'b1, 10'd0,    10'd0,    8'hFF, 1'b1, 3'd5},  // dash, top-left corner
    '{8'h2D, 1'b1, 10'd315,  10'd196,  8'h00, 1'b1, 3'd5},  // dash, bottom-right corner
    '{8'h20, 1'b1, 10'd10,   10'd10,   8'h55, 1'b1, 3'd0},  // space
    '{8'h00, 1'b0, 10'd1023, 10'd1023, 8'hFF, 1'b1, 3'd0},
    '{8'hFF, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},
    '{8'h40, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},  // just below 'A'
    '{8'h5B, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},  // just above 'Z'
    '{8'h2F, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},  // just below '0'
    '{8'h3A, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},  // just above '9'
    '{8'h61, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},  // lower case
    '{8'h30, 1'b1, 10'd1023, 10'd1023, 8'hAA, 1'b1, 3'd0},  // fully off screen
    '{8'h39, 1'b0, 10'd0,    10'd0,    8'h00, 1'b1, 3'd0},  // cursor past 1023
    '{8'h57, 1'b1, 10'd317,  10'd197,  8'h3C, 1'b0, 3'd0},  // clipped both ways
    '{8'h4D, 1'b1, 10'd2,    10'd195,  8'hC3, 1'b0, 3'd0},  // bottom rows clipped
    '{8'h38, 1'b1, 10'd100,  10'd100,  8'h0F, 1'b0, 3'd0},
    '{8'h49, 1'b0, 10'd0,    10'd0,    8'h00, 1'b0, 3'd0},
    '{8'h2D, 1'b0, 10'd0,    10'd0,    8'h00, 1'b0, 3'd0},
    '{8'h51, 1'b1, 10'd314,  10'd0,    8'hF0, 1'b0, 3'd0},  // right edge, all columns visible
    '{8'h4A, 1'b1, 10'd0,    10'd194,  8'h81, 1'b0, 3'd0},  // last row clipped
    '{8'h2D, 1'b1, 10'd316,  10'd0,    8'h7E, 1'b0, 3'd0}   // dash partly clipped
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ftr_char_if  char_if ();
  ftr_pixel_if pixel_if ();

  font_text_rasterizer_top #(
    .FB_WIDTH (FB_W),
    .FB_HEIGHT(FB_H)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .pixel_o(pixel_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pen state mirrored from the block
  logic [10:0] pen_x_q;
  logic [9:0]  pen_y_q;
  logic [7:0]  pen_ink_q;

  pixel_beat_t glyph_pix [35];
  pixel_beat_t pixel_q [$];

  int send_idle;
  int recv_stall;
  int mismatch_cnt;
  int pixels_seen;
  int quiet_cycles;

  function automatic font_rows_t font_rows(input logic [7:0] code);
    font_rows_t rows;
    if (code >= CH_A && code <= CH_Z) begin
      rows = ALPHA_FONT[code - CH_A];
    end else if (code >= CH_0 && code <= CH_9) begin
      rows = NUMERAL_FONT[code - CH_0];
    end else if (code == CH_DASH) begin
      rows = HYPHEN_FONT;
    end else begin
      rows = EMPTY_FONT;
    end
    return rows;
  endfunction

  // Fills glyph_pix with the visible pixels of one character, advances the pen.
  function automatic int rasterize(input char_beat_t c);
    font_rows_t  rows;
    logic [11:0] px;
    logic [10:0] py;
    logic [11:0] nxt;
    int          n;
    if (c.new_string) begin
      pen_x_q   = {1'b0, c.start_x};
      pen_y_q   = c.start_y;
      pen_ink_q = c.ink_color;
    end
    rows = font_rows(c.char_code);
    n = 0;
    for (int r = 0; r < 7; r++) begin
      for (int col = 0; col < 5; col++) begin
        px = {1'b0, pen_x_q} + 12'(col);
        py = {1'b0, pen_y_q} + 11'(r);
        if (rows[r][4 - col] && px < FB_W && py < FB_H) begin
          glyph_pix[n] = '{pixel_x: px[8:0], pixel_y: py[7:0], pixel_color: pen_ink_q,
                           last_pixel: 1'b0};
          n++;
        end
      end
    end
    if (n > 0) glyph_pix[n - 1].last_pixel = 1'b1;
    nxt = {1'b0, pen_x_q} + 12'd6;
    pen_x_q = (nxt > 12'(CURSOR_MAX)) ? CURSOR_MAX : nxt[10:0];
    return n;
  endfunction

  function automatic char_beat_t random_char(input logic load);
    char_beat_t c;
    int         pick;
    pick = $urandom_range(36);
    if ($urandom_range(99) < 80) begin
      c.char_code = (pick < 26) ? 8'(CH_A + pick) :
                    (pick < 36) ? 8'(CH_0 + pick - 26) : CH_DASH;
    end else begin
      c.char_code = 8'($urandom_range(255));
    end
    c.new_string = load;
    if ($urandom_range(99) < 85) begin
      c.start_x = 10'($urandom_range(330));
      c.start_y = 10'($urandom_range(205));
    end else begin
      c.start_x = 10'($urandom_range(1023));
      c.start_y = 10'($urandom_range(1023));
    end
    c.ink_color = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < PRINT_CAP) begin
      $display("pixel beat %0d: %s got %0d want %0d", pixels_seen, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // One character beat, then the pixels it should draw go on pixel_q.
  task automatic send_char(input char_beat_t c, input logic typed, input int n_typed);
    int n;
    while ($urandom_range(99) < send_idle) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid      <= 1'b1;
    char_if.char_code  <= c.char_code;
    char_if.new_string <= c.new_string;
    char_if.start_x    <= c.start_x;
    char_if.start_y    <= c.start_y;
    char_if.ink_color  <= c.ink_color;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    n = rasterize(c);
    if (typed) begin
      for (int i = 0; i < n_typed; i++) begin
        pixel_q.push_back('{pixel_x: 9'(c.start_x + 10'(i)), pixel_y: 8'(c.start_y + 10'd3),
                            pixel_color: c.ink_color, last_pixel: (i == n_typed - 1)});
      end
    end else begin
      for (int i = 0; i < n; i++) pixel_q.push_back(glyph_pix[i]);
    end
  endtask

  task automatic wait_drained();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure and the pixel checker
  initial begin
    pixel_beat_t want;
    pixel_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pixel_if.valid && pixel_if.ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected beat, pixel_x", pixel_if.pixel_x, -1);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_if.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", pixel_if.pixel_x, want.pixel_x);
          if (pixel_if.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", pixel_if.pixel_y, want.pixel_y);
          if (pixel_if.pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", pixel_if.pixel_color, want.pixel_color);
          if (pixel_if.last_pixel !== want.last_pixel)
            report_mismatch("last_pixel", pixel_if.last_pixel, want.last_pixel);
        end
        pixels_seen++;
      end
      pixel_if.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (pixel_if.valid && pixel_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    char_beat_t c;
    font_case_t fc;
    int         len;
    send_idle    = 0;
    recv_stall   = 0;
    mismatch_cnt = 0;
    pixels_seen  = 0;
    quiet_cycles = 0;
    pen_x_q      = '0;
    pen_y_q      = '0;
    pen_ink_q    = '0;
    rst_ni             <= 1'b0;
    char_if.valid      <= 1'b0;
    char_if.char_code  <= '0;
    char_if.new_string <= 1'b0;
    char_if.start_x    <= '0;
    char_if.start_y    <= '0;
    char_if.ink_color  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_CASES; i++) begin
      fc = FONT_CASES[i];
      c = '{char_code: fc.char_code, new_string: fc.new_string, start_x: fc.start_x,
            start_y: fc.start_y, ink_color: fc.ink_color};
      send_char(c, fc.typed, int'(fc.n_typed));
    end
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      if (phase == 0) begin
        // One long string from the far right, so the cursor runs into saturation
        c = random_char(1'b1);
        c.start_x = 10'($urandom_range(990, 1023));
        send_char(c, 1'b0, 0);
        for (int i = 0; i < 180; i++) send_char(random_char(1'b0), 1'b0, 0);
      end
      for (int sent = 0; sent < 20; sent += len + 1) begin
        if ($urandom_range(24) == 0) wait_drained();
        send_char(random_char(1'b1), 1'b0, 0);
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_char(random_char($urandom_range(9) == 0), 1'b0, 0);
        end
      end
      wait_drained();
    end

    char_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ftr_pkg.sv
rtl/core/ftr_if.sv
rtl/core/ftr_ctrl.sv
rtl/core/ftr_datapath.sv
rtl/core/font_text_rasterizer_top.sv
tb/font_text_rasterizer_top_tb.sv
